[sv/bdim_pkg.sv]
package bdim_pkg;

   // Field and register widths.
   localparam int CFG_W       = 16;
   localparam int SAMPLE_BITS = 12;
   localparam int DUTY_BITS   = 13;

   // Averaging window is a power of two, so the mean is a plain shift.
   localparam int AVG_SHIFT           = 4;
   localparam int SAMPLES_PER_AVERAGE = 1 << AVG_SHIFT;
   localparam int SUM_W               = SAMPLE_BITS + AVG_SHIFT;

   localparam longint unsigned DUTY_MAX   = (64'd1 << DUTY_BITS) - 64'd1;
   localparam longint unsigned SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 64'd1;

   // Scaling mean * DUTY_MAX / SAMPLE_MAX is done as one multiply by a rounded-up
   // reciprocal. With a shift of twice the sample width the error stays below
   // 1 / SAMPLE_MAX for every mean, so the truncated product is exact.
   localparam int SCALE_SHIFT = 2 * SAMPLE_BITS;
   localparam int SCALE_W     = SCALE_SHIFT + DUTY_BITS - SAMPLE_BITS + 1;
   localparam longint unsigned DUTY_SCALE_WIDE =
      ((DUTY_MAX << SCALE_SHIFT) + SAMPLE_MAX - 64'd1) / SAMPLE_MAX;
   localparam logic [SCALE_W-1:0] DUTY_SCALE = DUTY_SCALE_WIDE[SCALE_W-1:0];
   localparam int PROD_W = SAMPLE_BITS + SCALE_W;

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE    = 2'd0,
      CSR_LONG_PRESS  = 2'd1,
      CSR_SLOW_PERIOD = 2'd2,
      CSR_FAST_PERIOD = 2'd3
   } csr_index_type;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET    = 16'd30;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET  = 16'd500;
   localparam logic [CFG_W-1:0] SLOW_PERIOD_RESET = 16'd1000;
   localparam logic [CFG_W-1:0] FAST_PERIOD_RESET = 16'd250;

   typedef enum logic {
      PWR_OFF = 1'b0,
      PWR_ON  = 1'b1
   } power_state_type;

   typedef struct packed {
      logic short_press;
      logic long_press;
   } press_evt_type;

   typedef struct packed {
      logic                 update;
      logic [DUTY_BITS-1:0] duty;
   } avg_evt_type;

   // A programmed count of zero behaves as one.
   function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
      return (v == '0) ? CFG_W'(1) : v;
   endfunction

endpackage

[sv/bdim_req_if.sv]
interface bdim_req_if import bdim_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   button_level;
   logic                   sample_valid;
   logic [SAMPLE_BITS-1:0] light_sample;

   modport source (output valid, button_level, sample_valid, light_sample, input ready);
   modport sink   (input valid, button_level, sample_valid, light_sample, output ready);
endinterface

[sv/bdim_rsp_if.sv]
interface bdim_rsp_if import bdim_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DUTY_BITS-1:0] pwm_duty;
   logic                 system_on;
   logic                 fast_mode;
   logic                 short_press;
   logic                 long_press;
   logic                 brightness_update;

   modport source (output valid, pwm_duty, system_on, fast_mode, short_press, long_press,
                   brightness_update, input ready);
   modport sink   (input valid, pwm_duty, system_on, fast_mode, short_press, long_press,
                   brightness_update, output ready);
endinterface

[sv/button_led_dimmer_controller.sv]
// Button LED blink dimmer. Each item on the request channel is one millisecond
// tick carrying the raw button level (0 pressed) and an optional light sample.
// The button is debounced by a programmable countdown; a release after a
// settled press is reported as a short or a long press. A short press turns
// the system on with slow blinking and, when on, turns it off; a long press
// while on switches to fast blinking. Every 16 strobed light samples are
// averaged and scaled to a 13-bit duty that sets the brightness while on.
// Each tick produces exactly one result item with the duty now driven, the
// system and blink mode, and one-tick pulses for the press and brightness
// events. The block takes one item per clock: an item is captured in an input
// register, all of its work is done in a single pass of logic that ends in
// the result register, and the pair of registers keeps a full item rate while
// the result side is ready. The slowest path is the brightness scaling
// multiply in the averager. The user writes configuration registers through
// the csr port only while no item is in flight; the block itself does not
// enforce this. There is no read-back and there is no clearing pass after
// reset.
module button_led_dimmer_controller import bdim_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   bdim_req_if.sink             req_ch,
   bdim_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [CFG_W-1:0] debounce_ticks_ff;
   logic [CFG_W-1:0] long_press_ticks_ff;
   logic [CFG_W-1:0] slow_period_ticks_ff;
   logic [CFG_W-1:0] fast_period_ticks_ff;

   // Input stage.
   logic                   in_valid_ff, in_valid_in;
   logic                   in_level_ff;
   logic                   in_sample_valid_ff;
   logic [SAMPLE_BITS-1:0] in_sample_ff;

   // System and LED state.
   power_state_type        state_ff, state_in;
   logic                   enabled_ff, enabled_in;
   logic                   running_ff, running_in;
   logic                   fast_ff, fast_in;
   logic [CFG_W-1:0]       blink_left_ff, blink_left_in;
   logic                   phase_ff, phase_in;
   logic [DUTY_BITS-1:0]   stored_ff, stored_in;
   logic [DUTY_BITS-1:0]   driven_ff, driven_in;

   // Result stage.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DUTY_BITS-1:0]   rsp_duty_ff;
   logic                   rsp_on_ff;
   logic                   rsp_fast_ff;
   logic                   rsp_short_ff;
   logic                   rsp_long_ff;
   logic                   rsp_update_ff;

   logic                   step;
   press_evt_type          press_evt;
   avg_evt_type            avg_evt;

   // An item in the input register is worked on whenever the result register
   // is empty or is being emptied this cycle.
   assign step          = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   bdim_press u_press (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .level            (in_level_ff),
      .debounce_ticks   (debounce_ticks_ff),
      .long_press_ticks (long_press_ticks_ff),
      .evt              (press_evt)
   );

   bdim_avg u_avg (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .sample_valid (in_sample_valid_ff),
      .light_sample (in_sample_ff),
      .evt          (avg_evt)
   );

   // One tick of the blink timer, the system machine and the LED commands,
   // in that order, on top of the press and brightness events of this tick.
   always_comb begin
      state_in      = state_ff;
      enabled_in    = enabled_ff;
      running_in    = running_ff;
      fast_in       = fast_ff;
      blink_left_in = blink_left_ff;
      phase_in      = phase_ff;
      stored_in     = stored_ff;
      driven_in     = driven_ff;

      // Blink timer: toggle the phase at the end of each period; the dark
      // phase drives duty zero.
      if (running_ff) begin
         if (blink_left_ff <= CFG_W'(1)) begin
            phase_in      = !phase_ff;
            blink_left_in = at_least_one(fast_ff ? fast_period_ticks_ff
                                                 : slow_period_ticks_ff);
            driven_in     = (phase_in && enabled_ff) ? stored_ff : '0;
         end else begin
            blink_left_in = blink_left_ff - CFG_W'(1);
         end
      end

      unique case (state_ff)
         PWR_OFF: begin
            // A long press and any brightness computed while off are dropped.
            if (press_evt.short_press) begin
               state_in      = PWR_ON;
               enabled_in    = 1'b1;
               running_in    = 1'b1;
               fast_in       = 1'b0;
               blink_left_in = at_least_one(slow_period_ticks_ff);
            end
         end
         PWR_ON: begin
            if (press_evt.short_press) begin
               // Turning off stops the timer but leaves the blink phase alone.
               state_in      = PWR_OFF;
               enabled_in    = 1'b0;
               running_in    = 1'b0;
               fast_in       = 1'b0;
               blink_left_in = '0;
               driven_in     = '0;
            end
            if (press_evt.long_press) begin
               enabled_in    = 1'b1;
               running_in    = 1'b1;
               fast_in       = 1'b1;
               blink_left_in = at_least_one(fast_period_ticks_ff);
            end
            // A new brightness is driven at once, even in the dark phase.
            if (avg_evt.update && (state_in == PWR_ON)) begin
               stored_in = avg_evt.duty;
               if (enabled_in) begin
                  driven_in = avg_evt.duty;
               end
            end
         end
         default: begin
            state_in = PWR_OFF;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PWR_OFF;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= 1'b0;
         running_ff    <= 1'b0;
         fast_ff       <= 1'b0;
         blink_left_ff <= '0;
         phase_ff      <= 1'b0;
         stored_ff     <= '0;
         driven_ff     <= '0;
      end else if (step) begin
         enabled_ff    <= enabled_in;
         running_ff    <= running_in;
         fast_ff       <= fast_in;
         blink_left_ff <= blink_left_in;
         phase_ff      <= phase_in;
         stored_ff     <= stored_in;
         driven_ff     <= driven_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff    <= DEBOUNCE_RESET;
         long_press_ticks_ff  <= LONG_PRESS_RESET;
         slow_period_ticks_ff <= SLOW_PERIOD_RESET;
         fast_period_ticks_ff <= FAST_PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:    debounce_ticks_ff    <= csr_wdata;
            CSR_LONG_PRESS:  long_press_ticks_ff  <= csr_wdata;
            CSR_SLOW_PERIOD: slow_period_ticks_ff <= csr_wdata;
            CSR_FAST_PERIOD: fast_period_ticks_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_level_ff        <= req_ch.button_level;
         in_sample_valid_ff <= req_ch.sample_valid;
         in_sample_ff       <= req_ch.light_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_duty_ff   <= driven_in;
         rsp_on_ff     <= (state_in == PWR_ON);
         rsp_fast_ff   <= fast_in;
         rsp_short_ff  <= press_evt.short_press;
         rsp_long_ff   <= press_evt.long_press;
         rsp_update_ff <= avg_evt.update;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.pwm_duty          = rsp_duty_ff;
   assign rsp_ch.system_on         = rsp_on_ff;
   assign rsp_ch.fast_mode         = rsp_fast_ff;
   assign rsp_ch.short_press       = rsp_short_ff;
   assign rsp_ch.long_press        = rsp_long_ff;
   assign rsp_ch.brightness_update = rsp_update_ff;

   // The LED driver is enabled and its timer runs exactly while the system is on.
   a_enable_tracks_state: assert property (@(posedge clock) disable iff (reset)
      (enabled_ff == (state_ff == PWR_ON)) && (running_ff == (state_ff == PWR_ON)))
      else $error("LED enable or blink timer out of step with the system state");

   // While off, nothing can raise the driven duty above zero or set fast mode.
   a_dark_when_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PWR_OFF) |-> (driven_ff == '0) && !fast_ff)
      else $error("duty or fast mode set while the system is off");

   // A release is one press, never both kinds at once.
   a_one_press_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_short_ff && rsp_long_ff))
      else $error("short and long press reported together");

   // An item waiting for a full result register is kept, not dropped.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_ch.ready) |=> in_valid_ff)
      else $error("input item lost while the result side stalled");

endmodule

[sv/bdim_press.sv]
module bdim_press import bdim_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             level,
   input  logic [CFG_W-1:0] debounce_ticks,
   input  logic [CFG_W-1:0] long_press_ticks,
   output press_evt_type    evt
);

   logic             last_ff, last_in;
   logic [CFG_W-1:0] deb_ff, deb_in;
   logic             held_ff, held_in;
   logic [CFG_W-1:0] ticks_ff, ticks_in;
   logic [CFG_W-1:0] ticks_next;

   // Press length saturates at the top of the counter.
   assign ticks_next = (held_ff && (ticks_ff != '1)) ? ticks_ff + CFG_W'(1) : ticks_ff;

   always_comb begin
      last_in  = last_ff;
      deb_in   = deb_ff;
      held_in  = held_ff;
      ticks_in = ticks_next;
      evt      = '0;
      if (level != last_ff) begin
         last_in = level;
         deb_in  = at_least_one(debounce_ticks);
      end else if (deb_ff != '0) begin
         deb_in = deb_ff - CFG_W'(1);
         if (deb_ff == CFG_W'(1)) begin
            if (!level && !held_ff) begin
               held_in  = 1'b1;
               ticks_in = '0;
            end else if (level && held_ff) begin
               if (ticks_next >= long_press_ticks) begin
                  evt.long_press = 1'b1;
               end else begin
                  evt.short_press = 1'b1;
               end
               held_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= 1'b1;
         deb_ff   <= '0;
         held_ff  <= 1'b0;
         ticks_ff <= '0;
      end else if (step) begin
         last_ff  <= last_in;
         deb_ff   <= deb_in;
         held_ff  <= held_in;
         ticks_ff <= ticks_in;
      end
   end

endmodule

[sv/bdim_avg.sv]
module bdim_avg import bdim_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   sample_valid,
   input  logic [SAMPLE_BITS-1:0] light_sample,
   output avg_evt_type            evt
);

   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [AVG_SHIFT-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]       sum_full;
   logic [SAMPLE_BITS-1:0] mean;
   logic [PROD_W-1:0]      prod;
   logic                   last;

   assign sum_full = sum_ff + SUM_W'(light_sample);
   assign last     = (count_ff == AVG_SHIFT'(SAMPLES_PER_AVERAGE - 1));
   assign mean     = sum_full[SUM_W-1 -: SAMPLE_BITS];
   assign prod     = PROD_W'(mean) * PROD_W'(DUTY_SCALE);

   assign evt.update = sample_valid && last;
   assign evt.duty   = prod[SCALE_SHIFT +: DUTY_BITS];

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (sample_valid) begin
         if (last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_full;
            count_in = count_ff + AVG_SHIFT'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (step) begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

[tb/tb_button_led_dimmer_controller.sv]
`timescale 1ns / 1ps

// Self-checking bench for the button LED blink dimmer. Every request item is one
// millisecond tick; the block answers each tick with exactly one result item.
// The bench keeps its own model of the debounce, press tracking, blink timer,
// light averaging and on/off machine, predicts the status for every accepted
// tick and compares it field by field with the oldest prediction still waiting.
module tb_button_led_dimmer_controller;
   import bdim_pkg::*;

   // Status reported by the block after one tick.
   typedef struct packed {
      logic [DUTY_BITS-1:0] duty;
      logic                 sys_on;
      logic                 fast;
      logic                 short_hit;
      logic                 long_hit;
      logic                 bright_upd;
   } led_status_type;

   // One row of the directed table. When has_status is set, the row carries a
   // status that can be read straight off the behavior; otherwise the model
   // below supplies the expected status.
   typedef struct packed {
      logic                   level;
      logic                   strobe;
      logic [SAMPLE_BITS-1:0] sample;
      logic                   has_status;
      led_status_type         status;
   } tick_row_type;

   // Timing registers and traffic shape for one stretch of random ticks.
   typedef struct {
      logic [CFG_W-1:0] debounce;
      logic [CFG_W-1:0] long_press;
      logic [CFG_W-1:0] slow_period;
      logic [CFG_W-1:0] fast_period;
      int               ticks;
      int               run_max;
      int               send_idle_pct;
      int               recv_idle_pct;
   } timing_phase_type;

   localparam int             DIRECTED_ROWS = 25;
   localparam int             PHASES        = 5;
   localparam int             REPORT_LIMIT  = 10;
   localparam int             STALL_AT      = 800;
   localparam int             STALL_CYCLES  = 64;
   localparam int             DRAIN_LIMIT   = 5000;
   localparam led_status_type QUIET         = '0;
   // A short press from the off state: system comes on, slow blink, LED still dark.
   localparam led_status_type TURN_ON_SLOW  = '{13'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
   // Sixteen full-scale samples while on with fast blinking give full duty at once.
   localparam led_status_type FULL_FAST     = '{13'd8191, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
   // A short press while on: everything drops back to off.
   localparam led_status_type TURN_OFF      = '{13'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

   logic clock = 1'b0;
   logic reset;

   logic             csr_we;
   csr_index_type    csr_index;
   logic [CFG_W-1:0] csr_wdata;

   bdim_req_if req_if ();
   bdim_rsp_if rsp_if ();

   button_led_dimmer_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 4 ns period clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The run must finish long before this; if it does not, something hung.
   initial begin
      #2_000_000;
      $display("button_led_dimmer_controller verification failed");
      $finish;
   end

   // Timing registers as the block should currently hold them.
   logic [CFG_W-1:0] cfg_debounce;
   logic [CFG_W-1:0] cfg_long;
   logic [CFG_W-1:0] cfg_slow;
   logic [CFG_W-1:0] cfg_fast;

   // Model state: button filter, press tracker, on/off machine, blink driver
   // and light averager.
   logic                 lvl_last;
   int unsigned          bounce_left;
   logic                 held;
   int unsigned          held_len;
   power_state_type      pwr_state;
   logic                 drv_enabled;
   logic                 blink_run;
   logic                 blink_fast;
   int unsigned          blink_left;
   logic                 blink_phase;
   logic [DUTY_BITS-1:0] duty_saved;
   logic [DUTY_BITS-1:0] duty_driven;
   longint unsigned      light_sum;
   int                   light_count;

   // Status items predicted for accepted ticks, oldest first.
   led_status_type pending_status[$];

   // Traffic shape, changed by the stimulus between stretches.
   int send_idle_pct;
   int recv_idle_pct;

   // Bookkeeping for the verdict and the closing summary.
   int fail_count;
   int ticks_sent;
   int results_seen;
   int shorts_seen;
   int longs_seen;
   int updates_seen;
   int settings_used;

   // A programmed count of zero behaves as a count of one.
   function automatic int unsigned count_or_one(input logic [CFG_W-1:0] v);
      return (v == '0) ? 1 : int'(v);
   endfunction

   task automatic clear_model();
      lvl_last    = 1'b1;
      bounce_left = 0;
      held        = 1'b0;
      held_len    = 0;
      pwr_state   = PWR_OFF;
      drv_enabled = 1'b0;
      blink_run   = 1'b0;
      blink_fast  = 1'b0;
      blink_left  = 0;
      blink_phase = 1'b0;
      duty_saved  = '0;
      duty_driven = '0;
      light_sum   = 0;
      light_count = 0;
   endtask

   task automatic start_blinking(input logic fast);
      drv_enabled = 1'b1;
      blink_run   = 1'b1;
      blink_fast  = fast;
      blink_left  = count_or_one(fast ? cfg_fast : cfg_slow);
   endtask

   // Advances the model by one tick, in the block's order: blink timer, light
   // averaging, debounce and press tracking, then the on/off machine.
   task automatic predict_tick(input logic lvl, input logic strobe,
                               input logic [SAMPLE_BITS-1:0] smp,
                               output led_status_type st);
      logic                 short_ev;
      logic                 long_ev;
      logic                 avg_ev;
      logic [DUTY_BITS-1:0] avg_duty;
      longint unsigned      mean;
      short_ev = 1'b0;
      long_ev  = 1'b0;
      avg_ev   = 1'b0;
      avg_duty = '0;

      if (blink_run) begin
         if (blink_left <= 1) begin
            // Phase flips; the dark phase drives zero duty.
            blink_phase = ~blink_phase;
            blink_left  = count_or_one(blink_fast ? cfg_fast : cfg_slow);
            duty_driven = (blink_phase && drv_enabled) ? duty_saved : '0;
         end else begin
            blink_left = blink_left - 1;
         end
      end

      if (strobe) begin
         light_sum   = light_sum + smp;
         light_count = light_count + 1;
         if (light_count >= SAMPLES_PER_AVERAGE) begin
            mean        = light_sum / SAMPLES_PER_AVERAGE;
            avg_duty    = DUTY_BITS'((mean * DUTY_MAX) / SAMPLE_MAX);
            avg_ev      = 1'b1;
            light_sum   = 0;
            light_count = 0;
         end
      end

      // The press length saturates instead of wrapping.
      if (held && held_len < 32'hFFFF) held_len = held_len + 1;
      if (lvl != lvl_last) begin
         lvl_last    = lvl;
         bounce_left = count_or_one(cfg_debounce);
      end else if (bounce_left != 0) begin
         bounce_left = bounce_left - 1;
         if (bounce_left == 0) begin
            if (!lvl && !held) begin
               held     = 1'b1;
               held_len = 0;
            end else if (lvl && held) begin
               if (held_len >= cfg_long) long_ev = 1'b1;
               else short_ev = 1'b1;
               held = 1'b0;
            end
         end
      end

      if (pwr_state == PWR_OFF) begin
         // A long press while off does nothing, and a new average is dropped.
         if (short_ev) begin
            pwr_state = PWR_ON;
            start_blinking(1'b0);
         end
      end else begin
         if (short_ev) begin
            // Turning off keeps the blink phase as it is.
            pwr_state   = PWR_OFF;
            drv_enabled = 1'b0;
            blink_run   = 1'b0;
            blink_fast  = 1'b0;
            blink_left  = 0;
            duty_driven = '0;
         end
         if (long_ev) start_blinking(1'b1);
         if (avg_ev && pwr_state == PWR_ON) begin
            // A new brightness shows at once, even in the dark phase.
            duty_saved = avg_duty;
            if (drv_enabled) duty_driven = avg_duty;
         end
      end

      st = '{duty_driven, (pwr_state == PWR_ON), blink_fast, short_ev, long_ev, avg_ev};
   endtask

   // Writes all four timing registers on consecutive clocks. Only called while
   // no item is in flight.
   task automatic program_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                                 input logic [CFG_W-1:0] slow, input logic [CFG_W-1:0] fast);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= deb;
      @(posedge clock);
      csr_index <= CSR_LONG_PRESS;
      csr_wdata <= lng;
      @(posedge clock);
      csr_index <= CSR_SLOW_PERIOD;
      csr_wdata <= slow;
      @(posedge clock);
      csr_index <= CSR_FAST_PERIOD;
      csr_wdata <= fast;
      @(posedge clock);
      csr_we       <= 1'b0;
      cfg_debounce = deb;
      cfg_long     = lng;
      cfg_slow     = slow;
      cfg_fast     = fast;
      settings_used++;
   endtask

   // Offers one tick, possibly after a few idle cycles, and returns at the
   // clock edge where the block takes it. The expected status is queued there.
   task automatic send_tick(input logic lvl, input logic strobe,
                            input logic [SAMPLE_BITS-1:0] smp,
                            input logic has_status, input led_status_type status);
      led_status_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.button_level <= lvl;
      req_if.sample_valid <= strobe;
      req_if.light_sample <= smp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_tick(lvl, strobe, smp, predicted);
      pending_status.push_back(has_status ? status : predicted);
      ticks_sent++;
   endtask

   // Waits, with a bound so a stuck block still reaches the verdict, until every
   // predicted status has come back, then lets the block's registers settle.
   task automatic drain_results();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (pending_status.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Result side: checks each accepted status item and decides ready for the
   // next cycle. Once, after STALL_AT results, it holds ready low for a long
   // stretch so the block's registers fill and the request side backs up.
   int             stall_left = 0;
   logic           stall_done = 1'b0;
   led_status_type got_status;
   led_status_type want_status;

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_status = '{rsp_if.pwm_duty, rsp_if.system_on, rsp_if.fast_mode,
                        rsp_if.short_press, rsp_if.long_press, rsp_if.brightness_update};
         results_seen++;
         shorts_seen  += got_status.short_hit;
         longs_seen   += got_status.long_hit;
         updates_seen += got_status.bright_upd;
         if (pending_status.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: status item with no tick waiting: duty %0d on %0b fast %0b",
                        $realtime, got_status.duty, got_status.sys_on, got_status.fast);
         end else begin
            want_status = pending_status.pop_front();
            if (got_status.duty       !== want_status.duty      ||
                got_status.sys_on     !== want_status.sys_on    ||
                got_status.fast       !== want_status.fast      ||
                got_status.short_hit  !== want_status.short_hit ||
                got_status.long_hit   !== want_status.long_hit  ||
                got_status.bright_upd !== want_status.bright_upd) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $write("%0t: status %0d mismatch: expected duty %0d on %0b fast %0b ",
                         $realtime, results_seen,
                         want_status.duty, want_status.sys_on, want_status.fast);
                  $write("short %0b long %0b upd %0b, ",
                         want_status.short_hit, want_status.long_hit,
                         want_status.bright_upd);
                  $display("got duty %0d on %0b fast %0b short %0b long %0b upd %0b",
                           got_status.duty, got_status.sys_on, got_status.fast,
                           got_status.short_hit, got_status.long_hit,
                           got_status.bright_upd);
               end
            end
         end
      end

      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (results_seen == STALL_AT && !stall_done) begin
         stall_done = 1'b1;
         stall_left = STALL_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   tick_row_type     tick_rows[DIRECTED_ROWS];
   timing_phase_type phases[PHASES];

   initial begin : stimulus
      int                     run_left;
      int                     run_min;
      int                     pick;
      logic                   btn_level;
      logic                   strobe;
      logic [SAMPLE_BITS-1:0] smp;

      // Every input is known from the first instant.
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_DEBOUNCE;
      csr_wdata           = '0;
      req_if.valid        = 1'b0;
      req_if.button_level = 1'b1;
      req_if.sample_valid = 1'b0;
      req_if.light_sample = '0;
      rsp_if.ready        = 1'b0;
      fail_count    = 0;
      ticks_sent    = 0;
      results_seen  = 0;
      shorts_seen   = 0;
      longs_seen    = 0;
      updates_seen  = 0;
      settings_used = 0;
      send_idle_pct = 38;
      recv_idle_pct = 55;
      cfg_debounce  = DEBOUNCE_RESET;
      cfg_long      = LONG_PRESS_RESET;
      cfg_slow      = SLOW_PERIOD_RESET;
      cfg_fast      = FAST_PERIOD_RESET;
      clear_model();

      // Directed ticks, run with a one-tick debounce, a three-tick long press
      // threshold and very short blink periods so that a short press, a long
      // press, a full-scale average and a turn-off all happen within the table.
      // The button is released (1) unless noted.
      tick_rows = '{
         '{1'b1, 1'b0, 12'd0,    1'b1, QUIET},        // idle right after reset
         '{1'b0, 1'b0, 12'd0,    1'b1, QUIET},        // press edge starts debounce
         '{1'b0, 1'b0, 12'd0,    1'b1, QUIET},        // press settles
         '{1'b1, 1'b0, 12'd0,    1'b1, QUIET},        // release edge
         '{1'b1, 1'b0, 12'd0,    1'b1, TURN_ON_SLOW}, // short press turns it on
         '{1'b1, 1'b1, 12'd4095, 1'b0, QUIET},        // full-scale samples start
         '{1'b0, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b0, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b0, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b0, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b0, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b1, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b1, 1'b1, 12'd4095, 1'b0, QUIET},        // long press: fast blinking
         '{1'b1, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b1, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b1, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b1, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b1, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b1, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b1, 1'b1, 12'd4095, 1'b0, QUIET},
         '{1'b1, 1'b1, 12'd4095, 1'b1, FULL_FAST},    // sixteenth sample
         '{1'b0, 1'b1, 12'd0,    1'b0, QUIET},        // zero-scale samples begin
         '{1'b0, 1'b1, 12'd0,    1'b0, QUIET},
         '{1'b1, 1'b1, 12'd0,    1'b0, QUIET},
         '{1'b1, 1'b1, 12'd0,    1'b1, TURN_OFF}      // short press turns it off
      };

      // Random stretches, each with its own register setting: small values,
      // all zeros (treated as one, and every press counting as long), moderate
      // values, all ones (nothing ever settles or toggles) and the reset values.
      phases = '{
         '{16'd1,    16'd4,    16'd3,    16'd1,    250, 10,  38, 55},
         '{16'd0,    16'd0,    16'd0,    16'd0,    150, 6,   38, 55},
         '{16'd3,    16'd20,   16'd7,    16'd2,    250, 40,  55, 38},
         '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 60,  20,  0,  0},
         '{16'd30,   16'd500,  16'd1000, 16'd250,  400, 560, 0,  0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      program_timing(16'd1, 16'd3, 16'd2, 16'd1);
      foreach (tick_rows[i])
         send_tick(tick_rows[i].level, tick_rows[i].strobe, tick_rows[i].sample,
                   tick_rows[i].has_status, tick_rows[i].status);

      btn_level = 1'b1;
      foreach (phases[p]) begin
         drain_results();
         program_timing(phases[p].debounce, phases[p].long_press,
                        phases[p].slow_period, phases[p].fast_period);
         send_idle_pct = phases[p].send_idle_pct;
         recv_idle_pct = phases[p].recv_idle_pct;
         // Mostly well-formed button runs that outlast the debounce window,
         // mixed with one- or two-tick glitches that restart it.
         run_min  = count_or_one(cfg_debounce) + 1;
         if (run_min > phases[p].run_max) run_min = phases[p].run_max;
         run_left = 0;
         repeat (phases[p].ticks) begin
            if (run_left == 0) begin
               btn_level = ~btn_level;
               if ($urandom_range(0, 99) < 15) run_left = $urandom_range(1, 2);
               else run_left = $urandom_range(run_min, phases[p].run_max);
            end
            run_left--;
            strobe = ($urandom_range(0, 99) < 60);
            pick   = $urandom_range(0, 9);
            if (pick == 0) smp = '0;
            else if (pick == 1) smp = 12'd4095;
            else smp = SAMPLE_BITS'($urandom_range(0, 4095));
            send_tick(btn_level, strobe, smp, 1'b0, QUIET);
         end
      end

      drain_results();
      // Anything still waiting never came back.
      fail_count += pending_status.size();
      $display("Run covered %0d ticks under %0d timing settings, %0d status items checked.",
               ticks_sent, settings_used, results_seen);
      $display("Seen: %0d short presses, %0d long presses, %0d brightness updates; %0d errors.",
               shorts_seen, longs_seen, updates_seen, fail_count);
      if (fail_count == 0) begin
         $display("button_led_dimmer_controller verification clean");
      end else begin
         $display("button_led_dimmer_controller verification failed");
      end
      $finish;
   end

endmodule
